@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Clocked assertion helpers for the RTL; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in the same cycle as en
`define ASSERT_IMP(lbl, en, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
    else $error(msg);

// cond must hold in the cycle after en
`define ASSERT_NXT(lbl, en, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/sir_pkg.sv @@
// ----------------------------------------------------------------------------
// sir_pkg
// Types, constants and helpers for the sparse index reshape pipeline.
// ----------------------------------------------------------------------------
package sir_pkg;

  localparam int NUM_FIELDS  = 4;
  localparam int MAX_RANK_DEF = 4;
  localparam int DIM_W       = 16;
  localparam int OFF_W       = 64;
  localparam int RANK_W      = 3;
  localparam int CFG_IDX_W   = 8;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = OFF_W / DIV_BITS;
  localparam int NUM_STAGES  = NUM_FIELDS + (NUM_FIELDS - 1) * DIV_STEPS;

  localparam logic [CFG_IDX_W-1:0] REG_IN_RANK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RANK = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_DIMS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIMS = 8'd3;

  localparam logic [OFF_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][DIM_W-1:0] crd;
    logic [OFF_W-1:0]                 word;
    logic [DIM_W-1:0]                 rem;
    logic [NUM_FIELDS-1:0][OFF_W-1:0] res;
  } stage_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [OFF_W-1:0] packed_dims,
                                               input logic [1:0] j);
    logic [DIM_W-1:0] d;
    d = packed_dims[j*DIM_W +: DIM_W];
    return (d == '0) ? DIM_W'(1) : d;
  endfunction

  function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] r,
                                                 input logic [RANK_W-1:0] maxr);
    return (r > maxr) ? maxr : r;
  endfunction

endpackage

@@ rtl/sparse_index_reshape.sv @@
// An accepted word reaches its result word through 4 Horner multiply-add stages,
// then 3 divides of 16 stages at 4 quotient bits each.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous, active low; clears all stage valid bits and loads
// ranks of 1 and all dimensions of 1.
// ----------------------------------------------------------------------------
// sparse_index_reshape
// Row-major linearize of a coordinate tuple, then delinearize into a new shape.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_index_reshape #(
  parameter int MAX_RANK = sir_pkg::MAX_RANK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sir_pkg::OFF_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sir_pkg::DIM_W-1:0]       in_coord0,
  input  logic [sir_pkg::DIM_W-1:0]       in_coord1,
  input  logic [sir_pkg::DIM_W-1:0]       in_coord2,
  input  logic [sir_pkg::DIM_W-1:0]       in_coord3,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sir_pkg::OFF_W-1:0]       out_coord0,
  output logic [sir_pkg::OFF_W-1:0]       out_coord1,
  output logic [sir_pkg::OFF_W-1:0]       out_coord2,
  output logic [sir_pkg::OFF_W-1:0]       out_coord3
);

  localparam int NF  = sir_pkg::NUM_FIELDS;
  localparam int NST = sir_pkg::NUM_STAGES;
  localparam int DW  = sir_pkg::DIM_W;
  localparam int OW  = sir_pkg::OFF_W;

  logic [sir_pkg::RANK_W-1:0] in_rank_r, out_rank_r;
  logic [OW-1:0]              in_dims_r, out_dims_r;
  logic [sir_pkg::RANK_W-1:0] ir, orank;

  sir_pkg::stage_t pipe_r   [NST];
  sir_pkg::stage_t pipe_nxt [NST];
  logic [NST-1:0]  valid_r;
  logic            adv;

  assign cfg_ready = 1'b1;
  assign ir    = sir_pkg::eff_rank(in_rank_r, sir_pkg::RANK_W'(MAX_RANK));
  assign orank = sir_pkg::eff_rank(out_rank_r, sir_pkg::RANK_W'(MAX_RANK));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rank_r  <= sir_pkg::RANK_W'(1);
      out_rank_r <= sir_pkg::RANK_W'(1);
      in_dims_r  <= sir_pkg::DIMS_RESET;
      out_dims_r <= sir_pkg::DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sir_pkg::REG_IN_RANK:  in_rank_r  <= cfg_data[sir_pkg::RANK_W-1:0];
        sir_pkg::REG_OUT_RANK: out_rank_r <= cfg_data[sir_pkg::RANK_W-1:0];
        sir_pkg::REG_IN_DIMS:  in_dims_r  <= cfg_data;
        sir_pkg::REG_OUT_DIMS: out_dims_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !(valid_r[NST-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    sir_pkg::stage_t st;
    logic [DW:0]     rr;
    logic [DW-1:0]   r;
    logic [DW-1:0]   dv;
    int              t;
    int              k;
    int              sub;
    for (int s = 0; s < NST; s++) begin
      if (s == 0) begin
        st      = '0;
        st.crd  = {in_coord3, in_coord2, in_coord1, in_coord0};
      end else begin
        st = pipe_r[s-1];
      end
      if (s < NF) begin
        if (sir_pkg::RANK_W'(s) < ir) begin
          st.word = st.word * {{(OW-DW){1'b0}}, sir_pkg::dim_of(in_dims_r, 2'(s))}
                    + {{(OW-DW){1'b0}}, st.crd[s]};
        end
      end else begin
        t   = s - NF;
        k   = NF - 1 - t / sir_pkg::DIV_STEPS;
        sub = t % sir_pkg::DIV_STEPS;
        dv  = (sir_pkg::RANK_W'(k) < orank) ? sir_pkg::dim_of(out_dims_r, 2'(k))
                                            : DW'(1);
        r   = (sub == 0) ? '0 : st.rem;
        for (int b = 0; b < sir_pkg::DIV_BITS; b++) begin
          rr      = {r, st.word[OW-1]};
          st.word = {st.word[OW-2:0], 1'b0};
          if (rr >= {1'b0, dv}) begin
            rr         = rr - {1'b0, dv};
            st.word[0] = 1'b1;
          end
          r = rr[DW-1:0];
        end
        st.rem = r;
        if (sub == sir_pkg::DIV_STEPS - 1) begin
          st.res[k] = {{(OW-DW){1'b0}}, r};
        end
      end
      pipe_nxt[s] = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NST; s++) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  assign out_valid  = valid_r[NST-1];
  assign out_coord0 = (orank == '0) ? '0 : pipe_r[NST-1].word;
  assign out_coord1 = pipe_r[NST-1].res[1];
  assign out_coord2 = pipe_r[NST-1].res[2];
  assign out_coord3 = pipe_r[NST-1].res[3];

  `ASSERT_NXT(a_hold_valid, out_valid && out_stall, out_valid, "result dropped while stalled")
  `ASSERT_NXT(a_hold_data, out_valid && out_stall, $stable(out_coord1) && $stable(out_coord3),
              "result changed while stalled")
  `ASSERT_IMP(a_rank_zero, out_valid && orank < 3'd4, out_coord3 == '0,
              "slot beyond rank not zero")
  `ASSERT_IMP(a_stall_src, in_stall, out_valid && out_stall, "input stalled without cause")

endmodule

@@ tb/sv/sir_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir_checker
// Watches the config, input and result channels of sparse_index_reshape,
// predicts each result word from the current ranks and dimensions, and
// compares it field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sir_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sir_pkg::OFF_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [sir_pkg::DIM_W-1:0]     in_coord0,
  input  logic [sir_pkg::DIM_W-1:0]     in_coord1,
  input  logic [sir_pkg::DIM_W-1:0]     in_coord2,
  input  logic [sir_pkg::DIM_W-1:0]     in_coord3,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [sir_pkg::OFF_W-1:0]     out_coord0,
  input  logic [sir_pkg::OFF_W-1:0]     out_coord1,
  input  logic [sir_pkg::OFF_W-1:0]     out_coord2,
  input  logic [sir_pkg::OFF_W-1:0]     out_coord3,
  output int                            fail_count,
  output int                            pending,
  output int                            words_seen
);

  typedef logic [sir_pkg::NUM_FIELDS-1:0][sir_pkg::OFF_W-1:0] coords_t;

  logic [sir_pkg::RANK_W-1:0] cur_in_rank;
  logic [sir_pkg::RANK_W-1:0] cur_out_rank;
  logic [sir_pkg::OFF_W-1:0]  cur_in_dims;
  logic [sir_pkg::OFF_W-1:0]  cur_out_dims;
  coords_t                    reshaped_q[$];

  function automatic int rank_used(input logic [sir_pkg::RANK_W-1:0] r);
    return (int'(r) > sir_pkg::MAX_RANK_DEF) ? sir_pkg::MAX_RANK_DEF : int'(r);
  endfunction

  function automatic logic [sir_pkg::OFF_W-1:0] dim_field(
      input logic [sir_pkg::OFF_W-1:0] dims, input int j);
    logic [sir_pkg::OFF_W-1:0] d;
    d = (dims >> (16 * j)) & 64'hFFFF;
    return (d == '0) ? 64'd1 : d;
  endfunction

  function automatic logic [sir_pkg::OFF_W-1:0] stride(
      input logic [sir_pkg::OFF_W-1:0] dims, input int j, input int rank);
    logic [sir_pkg::OFF_W-1:0] s;
    s = sir_pkg::OFF_W'(1);
    for (int k = j + 1; k < rank; k++) s = s * dim_field(dims, k);
    return s;
  endfunction

  function automatic coords_t reshape(
      input logic [sir_pkg::NUM_FIELDS-1:0][sir_pkg::DIM_W-1:0] crd);
    int                        ir;
    int                        orank;
    logic [sir_pkg::OFF_W-1:0] offset;
    logic [sir_pkg::OFF_W-1:0] s;
    coords_t                   res;
    ir = rank_used(cur_in_rank);
    orank = rank_used(cur_out_rank);
    offset = '0;
    res = '0;
    for (int j = 0; j < ir; j++)
      offset = offset + sir_pkg::OFF_W'(crd[j]) * stride(cur_in_dims, j, ir);
    for (int j = 0; j < orank; j++) begin
      s = stride(cur_out_dims, j, orank);
      res[j] = offset / s;
      offset = offset % s;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    coords_t got;
    coords_t want;
    if (!rst_n) begin
      cur_in_rank  <= 3'd1;
      cur_out_rank <= 3'd1;
      cur_in_dims  <= sir_pkg::DIMS_RESET;
      cur_out_dims <= sir_pkg::DIMS_RESET;
      reshaped_q.delete();
      fail_count <= 0;
      pending <= 0;
      words_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sir_pkg::REG_IN_RANK:  cur_in_rank  <= cfg_data[sir_pkg::RANK_W-1:0];
          sir_pkg::REG_OUT_RANK: cur_out_rank <= cfg_data[sir_pkg::RANK_W-1:0];
          sir_pkg::REG_IN_DIMS:  cur_in_dims  <= cfg_data;
          sir_pkg::REG_OUT_DIMS: cur_out_dims <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        reshaped_q.push_back(reshape({in_coord3, in_coord2, in_coord1, in_coord0}));
      if (out_valid && !out_stall) begin
        got = {out_coord3, out_coord2, out_coord1, out_coord0};
        words_seen <= words_seen + 1;
        if (reshaped_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = reshaped_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              for (int j = 0; j < sir_pkg::NUM_FIELDS; j++)
                $display("ERROR: out_coord%0d expected %h got %h", j, want[j], got[j]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= reshaped_q.size();
    end
  end
endmodule

@@ tb/sv/tb_sparse_index_reshape.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_index_reshape
// Drives coordinate tuples through sparse_index_reshape under several
// shape settings and idle/stall mixes; sir_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sparse_index_reshape;

  localparam int LATENCY = 52;
  localparam logic [sir_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [sir_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sir_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sir_pkg::OFF_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [sir_pkg::DIM_W-1:0]     in_coord0, in_coord1, in_coord2, in_coord3;
  logic                          out_valid;
  logic                          out_stall;
  logic [sir_pkg::OFF_W-1:0]     out_coord0, out_coord1, out_coord2, out_coord3;
  int                            fail_count;
  int                            pending;
  int                            words_seen;
  int                            send_idle_pct;
  int                            recv_stall_pct;
  int                            settings_run;

  sparse_index_reshape i_dut (.*);

  sir_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(input logic [sir_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sir_pkg::OFF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_shape(input int ir, input int orank,
                           input logic [sir_pkg::OFF_W-1:0] idims,
                           input logic [sir_pkg::OFF_W-1:0] odims);
    drain();
    write_reg(sir_pkg::REG_IN_RANK, sir_pkg::OFF_W'(ir));
    write_reg(sir_pkg::REG_OUT_RANK, sir_pkg::OFF_W'(orank));
    write_reg(sir_pkg::REG_IN_DIMS, idims);
    write_reg(sir_pkg::REG_OUT_DIMS, odims);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic send_word(input logic [sir_pkg::DIM_W-1:0] c0,
                           input logic [sir_pkg::DIM_W-1:0] c1,
                           input logic [sir_pkg::DIM_W-1:0] c2,
                           input logic [sir_pkg::DIM_W-1:0] c3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coord0 <= c0;
    in_coord1 <= c1;
    in_coord2 <= c2;
    in_coord3 <= c3;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [sir_pkg::DIM_W-1:0] rand_crd(
      input logic [sir_pkg::DIM_W-1:0] dim);
    if ($urandom_range(9) == 0) return sir_pkg::DIM_W'($urandom());
    return (dim <= 1) ? '0 : sir_pkg::DIM_W'($urandom_range(dim - 1));
  endfunction

  function automatic logic [sir_pkg::OFF_W-1:0] rand_dims(input int mode);
    logic [sir_pkg::OFF_W-1:0] d;
    d = '0;
    for (int j = 0; j < 4; j++)
      case (mode)
        0: d[16*j +: 16] = sir_pkg::DIM_W'($urandom_range(8));
        1: d[16*j +: 16] = sir_pkg::DIM_W'($urandom_range(300));
        default: d[16*j +: 16] = sir_pkg::DIM_W'($urandom());
      endcase
    return d;
  endfunction

  initial begin
    logic [sir_pkg::OFF_W-1:0] idims;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_coord0 = '0;
    in_coord1 = '0;
    in_coord2 = '0;
    in_coord3 = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    settings_run = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    set_shape(4, 4, 64'h0004_0003_0002_0005, 64'h0002_0006_0005_0002);
    send_word(0, 0, 0, 0);
    send_word(4, 1, 2, 3);
    send_word(2, 0, 1, 2);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_shape(4, 4, 64'h0000_0000_0000_0000, 64'h0000_0007_0000_0003);
    send_word(16'hAAAA, 16'h5555, 16'h1234, 16'hFFFF);
    set_shape(7, 6, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    set_shape(0, 3, 64'h0004_0003_0002_0005, 64'h0002_0006_0005_0002);
    send_word(3, 3, 3, 3);
    set_shape(3, 0, 64'h0004_0003_0002_0005, 64'h0002_0006_0005_0002);
    send_word(3, 3, 3, 3);
    set_shape(1, 2, 64'h0001_0001_0001_0001, 64'h0001_0001_0001_0010);
    send_word(16'h1234, 0, 0, 0);
    drain();
    write_reg(REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_UNUSED_HI, 64'h0);
    cfg_valid <= 1'b0;
    send_word(16'h00FF, 16'hFFFF, 0, 0);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      idims = rand_dims(phase % 3);
      set_shape($urandom_range(7), $urandom_range(7), idims, rand_dims($urandom_range(2)));
      for (int n = 0; n < 80; n++) begin
        send_word(rand_crd(idims[15:0]), rand_crd(idims[31:16]),
                  rand_crd(idims[47:32]), rand_crd(idims[63:48]));
        if (phase == 5 && n == 40) begin
          drain();
        end
      end
    end
    drain();

    $display("Covered %0d shape settings, %0d result words checked.", settings_run, words_seen);
    if (fail_count == 0) begin
      $display("PASS sparse_index_reshape");
    end else begin
      $display("FAIL sparse_index_reshape");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL sparse_index_reshape");
    $finish;
  end
endmodule

@@ sparse_index_reshape.f @@
+incdir+rtl
rtl/sir_pkg.sv
rtl/sparse_index_reshape.sv
tb/sv/sir_checker.sv
tb/sv/tb_sparse_index_reshape.sv
